// ===== rtl/pk1v_pkg.sv =====
// pk1v_pkg: shared types, constants and the digest info table for the
// pkcs1 type 1 sha-1 signature block check. no dependencies.

package pk1v_pkg;

	localparam int MAX_BLOCK_BYTES = 2048;
	localparam int DIGEST_BYTES    = 20;
	localparam int MIN_PAD_BYTES   = 8;
	localparam int SHORT_LIMIT     = 11;
	localparam int PREFIX_BYTES    = 15;
	localparam int PAYLOAD_BYTES   = PREFIX_BYTES + DIGEST_BYTES;

	localparam int CNT_W = 12;
	localparam int IDX_W = $clog2(PAYLOAD_BYTES + 1);
	localparam int DIG_W = $clog2(DIGEST_BYTES);

	localparam logic [CNT_W-1:0] BYTE_CAP  = CNT_W'(MAX_BLOCK_BYTES + 1);
	localparam logic [CNT_W-1:0] BYTE_MAX  = CNT_W'(MAX_BLOCK_BYTES);
	localparam logic [CNT_W-1:0] PAD_CAP   = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] PAD_MIN   = CNT_W'(MIN_PAD_BYTES);
	localparam logic [CNT_W-1:0] SHORT_LEN = CNT_W'(SHORT_LIMIT);

	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_TYPE = 8'h01;
	localparam logic [7:0] BYTE_PAD  = 8'hff;

	typedef enum logic [2:0] {
		PH_LEAD    = 3'd0,
		PH_TYPE    = 3'd1,
		PH_PAD     = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_HALT    = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_SHORT  = 3'd1,
		ST_LEAD   = 3'd2,
		ST_TYPE   = 3'd3,
		ST_PAD    = 3'd4,
		ST_NOSEP  = 3'd5,
		ST_PADCNT = 3'd6,
		ST_BADSIG = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		REG_DIGEST_HIGH = 2'd0,
		REG_DIGEST_MID  = 2'd1,
		REG_DIGEST_LOW  = 2'd2
	} reg_index_t;

	// sha-1 digest info prefix
	function automatic logic [7:0] prefix_byte(input logic [3:0] k);
		logic [7:0] b;
		case (k)
			4'd0:    b = 8'h30;
			4'd1:    b = 8'h21;
			4'd2:    b = 8'h30;
			4'd3:    b = 8'h09;
			4'd4:    b = 8'h06;
			4'd5:    b = 8'h05;
			4'd6:    b = 8'h2b;
			4'd7:    b = 8'h0e;
			4'd8:    b = 8'h03;
			4'd9:    b = 8'h02;
			4'd10:   b = 8'h1a;
			4'd11:   b = 8'h05;
			4'd12:   b = 8'h00;
			4'd13:   b = 8'h04;
			4'd14:   b = 8'h14;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// keep the earliest error code
	function automatic status_t keep_first(input status_t fe, input status_t code);
		return (fe == ST_OK) ? code : fe;
	endfunction

endpackage

// ===== rtl/pkcs1_type1_sha1_verify_check.sv =====
// pkcs1_type1_sha1_verify_check: top level of the type 1 padding and sha-1
// digest check. uses pk1v_pkg and pk1v_expect.
//
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   block_byte, last_byte
// res      output     res_valid / res_stall status, valid_res
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one byte per cycle sustained while in_stall is low: a byte is registered,
// then the block state and the single payload compare update from it.
// the result register loads once the final byte is registered and in_stall is low.
// reset clears the block state, the digest registers and the input and result valid flags.
// in_stall rises only while the final byte waits on a full, stalled result
// register; other bytes keep flowing under res_stall.

module pkcs1_type1_sha1_verify_check import pk1v_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  block_byte,
	input  logic        last_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [2:0]  status,
	output logic        valid_res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	logic [63:0] digest_high_q;
	logic [63:0] digest_mid_q;
	logic [31:0] digest_low_q;

	phase_t           phase_q, phase_n;
	status_t          first_err_q, first_err_n, res_code;
	logic [CNT_W-1:0] byte_cnt_q, byte_cnt_n;
	logic [CNT_W-1:0] pad_cnt_q, pad_cnt_n;
	logic [IDX_W-1:0] pay_idx_q, pay_idx_n;

	logic        res_valid_q;
	logic [2:0]  status_q;
	logic        valid_res_q;

	logic        slot_free;
	logic        step;
	logic [7:0]  exp_byte;

	assign cfg_ready = 1'b1;
	assign slot_free = !res_valid_q || !res_stall;
	assign in_stall  = valid_s1 && last_s1 && !slot_free;
	assign step      = valid_s1 && !in_stall;

	assign res_valid = res_valid_q;
	assign status    = status_q;
	assign valid_res = valid_res_q;

	pk1v_expect u_expect (
		.idx         (pay_idx_q),
		.digest_high (digest_high_q),
		.digest_mid  (digest_mid_q),
		.digest_low  (digest_low_q),
		.exp_byte    (exp_byte)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digest_high_q <= '0;
			digest_mid_q  <= '0;
			digest_low_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DIGEST_HIGH: digest_high_q <= cfg_data;
				REG_DIGEST_MID:  digest_mid_q  <= cfg_data;
				REG_DIGEST_LOW:  digest_low_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= block_byte;
			last_s1 <= last_byte;
		end
	end

	// per-byte block state update
	always_comb begin
		phase_n     = phase_q;
		first_err_n = first_err_q;
		pad_cnt_n   = pad_cnt_q;
		pay_idx_n   = pay_idx_q;
		byte_cnt_n  = (byte_cnt_q < BYTE_CAP) ? byte_cnt_q + 1'b1 : byte_cnt_q;

		if (byte_cnt_n > BYTE_MAX) begin
			first_err_n = keep_first(first_err_n, ST_BADSIG);
			phase_n     = PH_HALT;
		end

		unique case (phase_q)
			PH_LEAD: begin
				if (byte_s1 != BYTE_ZERO) begin
					first_err_n = keep_first(first_err_n, ST_LEAD);
					phase_n     = PH_HALT;
				end else begin
					phase_n = PH_TYPE;
				end
			end
			PH_TYPE: begin
				if (byte_s1 != BYTE_TYPE) begin
					first_err_n = keep_first(first_err_n, ST_TYPE);
					phase_n     = PH_HALT;
				end else begin
					phase_n = PH_PAD;
				end
			end
			PH_PAD: begin
				if (byte_s1 == BYTE_PAD) begin
					if (pad_cnt_q < PAD_CAP) pad_cnt_n = pad_cnt_q + 1'b1;
				end else if (byte_s1 == BYTE_ZERO) begin
					if (pad_cnt_q < PAD_MIN) begin
						first_err_n = keep_first(first_err_n, ST_PADCNT);
						phase_n     = PH_HALT;
					end else begin
						phase_n = PH_PAYLOAD;
					end
				end else begin
					first_err_n = keep_first(first_err_n, ST_PAD);
					phase_n     = PH_HALT;
				end
			end
			PH_PAYLOAD: begin
				if (pay_idx_q >= IDX_W'(PAYLOAD_BYTES) || byte_s1 != exp_byte) begin
					first_err_n = keep_first(first_err_n, ST_BADSIG);
					phase_n     = PH_HALT;
				end else begin
					pay_idx_n = pay_idx_q + 1'b1;
				end
			end
			default: ;
		endcase

		// end of block checks; over-length is checked first, so its error code is kept here
		if (phase_n == PH_PAD) begin
			res_code = keep_first(first_err_n, ST_NOSEP);
		end else if (phase_n == PH_PAYLOAD && pay_idx_n != IDX_W'(PAYLOAD_BYTES)) begin
			res_code = keep_first(first_err_n, ST_BADSIG);
		end else begin
			res_code = first_err_n;
		end
		if (byte_cnt_n < SHORT_LEN) res_code = ST_SHORT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEAD;
			first_err_q <= ST_OK;
			byte_cnt_q  <= '0;
			pad_cnt_q   <= '0;
			pay_idx_q   <= '0;
		end else if (step) begin
			if (last_s1) begin
				phase_q     <= PH_LEAD;
				first_err_q <= ST_OK;
				byte_cnt_q  <= '0;
				pad_cnt_q   <= '0;
				pay_idx_q   <= '0;
			end else begin
				phase_q     <= phase_n;
				first_err_q <= first_err_n;
				byte_cnt_q  <= byte_cnt_n;
				pad_cnt_q   <= pad_cnt_n;
				pay_idx_q   <= pay_idx_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			status_q    <= res_code;
			valid_res_q <= (res_code == ST_OK);
		end
	end

endmodule

// ===== rtl/pk1v_expect.sv =====
// pk1v_expect: expected payload byte at a given payload position, from the
// fixed digest info prefix and the configured digest. uses pk1v_pkg.

module pk1v_expect import pk1v_pkg::*; (
	input  logic [IDX_W-1:0] idx,
	input  logic [63:0]      digest_high,
	input  logic [63:0]      digest_mid,
	input  logic [31:0]      digest_low,
	output logic [7:0]       exp_byte
);

	logic [8*DIGEST_BYTES-1:0] dig_cat;
	logic [7:0]                dig [DIGEST_BYTES];
	logic [IDX_W-1:0]          dig_off;

	assign dig_cat = {digest_high, digest_mid, digest_low};
	assign dig_off = idx - IDX_W'(PREFIX_BYTES);

	always_comb begin
		for (int i = 0; i < DIGEST_BYTES; i++) begin
			dig[i] = dig_cat[8*(DIGEST_BYTES-1-i) +: 8];
		end
	end

	always_comb begin
		if (idx < IDX_W'(PREFIX_BYTES)) begin
			exp_byte = prefix_byte(idx[3:0]);
		end else if (idx < IDX_W'(PAYLOAD_BYTES)) begin
			exp_byte = dig[dig_off[DIG_W-1:0]];
		end else begin
			exp_byte = 8'h00;
		end
	end

endmodule
